// File: design/qmn_pkg.sv
// Shared types and constants for the quaternion multiply and normalize unit.
// No dependencies; every other design file imports this package.
package qmn_pkg;

    localparam int MAG_W     = 31;  // normalized magnitude width
    localparam int ROOT_W    = 32;  // integer square root width
    localparam int FRAC_W    = 30;  // Q1.30 fraction bits
    localparam int SQ_STEPS  = 32;  // one root bit per stage
    localparam int DIV_STEPS = 31;  // one quotient bit per stage

    localparam logic [1:0] FUNC_AB      = 2'd0;
    localparam logic [1:0] FUNC_CONJA_B = 2'd1;
    localparam logic [1:0] FUNC_A_CONJB = 2'd2;
    localparam logic [1:0] FUNC_CONJA   = 2'd3;

    // Bit 4*c+t is set where term t of component c is subtracted.
    localparam logic [15:0] TERM_NEG = 16'h7214;

    // One word handed from the front part to the back part.
    typedef struct packed {
        logic [3:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
        logic [63:0]           sumsq;
    } norm_item_t;

endpackage

// File: design/qmn_front.sv
// Front part: products, sums, magnitudes, common normalizing shift and sum of squares.
// Depends on qmn_pkg.
module qmn_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         func,
    input  logic [3:0][31:0]   a,
    input  logic [3:0][31:0]   b,
    output logic               out_valid,
    output qmn_pkg::norm_item_t out_item
);
    import qmn_pkg::*;

    function automatic logic [2:0] lead8(input logic [7:0] x);
        logic [2:0] p;
        p = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (x[i])
            begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

    logic [10:1]              vld_reg;
    logic [1:0]               func1_reg, func2_reg, func3_reg;
    logic [3:0][31:0]         a1_reg, a2_reg, a3_reg, b1_reg;
    logic signed [63:0]       prod_reg [16];
    logic signed [63:0]       quart_next [16];
    logic signed [63:0]       term_reg [16];
    logic signed [63:0]       q_reg [4];
    logic [3:0][62:0]         mag5_reg, mag6_reg, mag7_reg;
    logic [2:0]               sgn5_reg, sgn6_reg, sgn7_reg, sgn8_reg, sgn9_reg;
    logic [7:0]               grp_nz_reg;
    logic [7:0][2:0]          grp_pos_reg;
    logic [5:0]               lead_reg;
    logic                     zero7_reg, zero8_reg, zero9_reg;
    logic [3:0][MAG_W-1:0]    mag8_reg, mag9_reg, mag8_next;
    logic [3:0][61:0]         sq9_reg;
    logic [63:0]              orv_next;
    logic [5:0]               lead_next;
    norm_item_t               item_reg;
    logic                     conja_next, conjb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[9:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        func1_reg <= func;
        a1_reg    <= a;
        b1_reg    <= b;
        func2_reg <= func1_reg;
        a2_reg    <= a1_reg;
        func3_reg <= func2_reg;
        a3_reg    <= a2_reg;
    end

    assign conja_next = (func2_reg == FUNC_CONJA_B) || (func2_reg == FUNC_CONJA);
    assign conjb_next = (func2_reg == FUNC_A_CONJB);

    for (genvar c = 0; c < 4; c++)
    begin : g_comp
        for (genvar t = 0; t < 4; t++)
        begin : g_term
            localparam int BI = 3 ^ c ^ t;
            logic flip;
            assign quart_next[c*4+t] = (prod_reg[c*4+t]
                + $signed({62'd0, {2{prod_reg[c*4+t][63]}}})) >>> 2;
            assign flip = TERM_NEG[c*4+t] ^ (conja_next && (t < 3))
                        ^ (conjb_next && (BI < 3));
            always_ff @(posedge clk)
            begin
                prod_reg[c*4+t] <= $signed(b1_reg[BI]) * $signed(a1_reg[t]);
                term_reg[c*4+t] <= flip ? -quart_next[c*4+t] : quart_next[c*4+t];
            end
        end
    end

    // Component sums, or the conjugate of a alone.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (func3_reg == FUNC_CONJA)
            begin
                if (c < 3)
                begin
                    q_reg[c] <= -$signed({{32{a3_reg[c][31]}}, a3_reg[c]});
                end
                else
                begin
                    q_reg[c] <= $signed({{32{a3_reg[c][31]}}, a3_reg[c]});
                end
            end
            else
            begin
                q_reg[c] <= term_reg[c*4] + term_reg[c*4+1]
                          + term_reg[c*4+2] + term_reg[c*4+3];
            end
        end
    end

    // Magnitudes; a negative scalar flips every sign.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            mag5_reg[c] <= q_reg[c][63] ? 63'(-q_reg[c]) : q_reg[c][62:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            sgn5_reg[c] <= q_reg[c][63] ^ q_reg[3][63];
        end
    end

    assign orv_next = {1'b0, mag5_reg[0] | mag5_reg[1] | mag5_reg[2] | mag5_reg[3]};

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 8; g++)
        begin
            grp_nz_reg[g]  <= |orv_next[g*8 +: 8];
            grp_pos_reg[g] <= lead8(orv_next[g*8 +: 8]);
        end
        mag6_reg <= mag5_reg;
        sgn6_reg <= sgn5_reg;
    end

    always_comb
    begin
        lead_next = 6'd0;
        for (int g = 0; g < 8; g++)
        begin
            if (grp_nz_reg[g])
            begin
                lead_next = {3'(g), grp_pos_reg[g]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lead_reg  <= lead_next;
        zero7_reg <= ~|grp_nz_reg;
        mag7_reg  <= mag6_reg;
        sgn7_reg  <= sgn6_reg;
    end

    // Shift all four so the largest lies in [2^30, 2^31).
    always_comb
    begin
        logic [62:0] sh;
        for (int c = 0; c < 4; c++)
        begin
            if (lead_reg >= 6'(FRAC_W))
            begin
                sh = mag7_reg[c] >> (lead_reg - 6'(FRAC_W));
            end
            else
            begin
                sh = mag7_reg[c] << (6'(FRAC_W) - lead_reg);
            end
            mag8_next[c] = sh[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mag8_reg  <= mag8_next;
        zero8_reg <= zero7_reg;
        sgn8_reg  <= sgn7_reg;
        for (int c = 0; c < 4; c++)
        begin
            sq9_reg[c] <= 62'(mag8_reg[c]) * 62'(mag8_reg[c]);
        end
        mag9_reg  <= mag8_reg;
        zero9_reg <= zero8_reg;
        sgn9_reg  <= sgn8_reg;
        item_reg.mag   <= mag9_reg;
        item_reg.neg   <= sgn9_reg;
        item_reg.zero  <= zero9_reg;
        item_reg.sumsq <= 64'(sq9_reg[0]) + 64'(sq9_reg[1])
                        + 64'(sq9_reg[2]) + 64'(sq9_reg[3]);
    end

    assign out_valid = vld_reg[10];
    assign out_item  = item_reg;

endmodule

// File: design/qmn_queue.sv
// Two-word queue between the front and back parts.
// Depends on qmn_pkg.
module qmn_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  qmn_pkg::norm_item_t din,
    input  logic                pop,
    output qmn_pkg::norm_item_t dout,
    output logic                not_empty,
    output logic                full
);
    import qmn_pkg::*;

    norm_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign do_pop    = pop && not_empty;
    assign dout      = mem_reg[rd_ptr_reg];
    assign cnt_next  = cnt_reg + 2'(push) - 2'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ do_pop;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");
    a_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && not_empty && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("queue count did not fall on a read");
`endif

endmodule

// File: design/qmn_back.sv
// Back part: pipelined integer square root and four pipelined long dividers.
// Depends on qmn_pkg.
module qmn_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  qmn_pkg::norm_item_t    in_item,
    output logic                   out_valid,
    output logic [3:0][30:0]       quo,
    output logic [2:0]             neg,
    output logic                   zero
);
    import qmn_pkg::*;

    logic                    sq_vld_reg  [SQ_STEPS+1];
    logic [35:0]             sq_rem_reg  [SQ_STEPS+1];
    logic [ROOT_W-1:0]       sq_root_reg [SQ_STEPS+1];
    norm_item_t              sq_item_reg [SQ_STEPS+1];

    logic                    dv_vld_reg  [DIV_STEPS+1];
    logic [3:0][32:0]        dv_rem_reg  [DIV_STEPS+1];
    logic [3:0][30:0]        dv_low_reg  [DIV_STEPS+1];
    logic [3:0][30:0]        dv_quo_reg  [DIV_STEPS+1];
    logic [ROOT_W-1:0]       dv_div_reg  [DIV_STEPS+1];
    logic [2:0]              dv_neg_reg  [DIV_STEPS+1];
    logic                    dv_zero_reg [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
        end
        else
        begin
            sq_vld_reg[0] <= in_valid;
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_item_reg[0] <= in_item;
    end

    // Square root, two radicand bits per stage.
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [35:0] rem_next, trial_next;
        logic        ge_next;
        assign rem_next   = {sq_rem_reg[j][33:0], sq_item_reg[j].sumsq[63:62]};
        assign trial_next = {2'b00, sq_root_reg[j], 2'b01};
        assign ge_next    = rem_next >= trial_next;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[j+1]  <= ge_next ? rem_next - trial_next : rem_next;
            sq_root_reg[j+1] <= {sq_root_reg[j][ROOT_W-2:0], ge_next};
            sq_item_reg[j+1].mag   <= sq_item_reg[j].mag;
            sq_item_reg[j+1].neg   <= sq_item_reg[j].neg;
            sq_item_reg[j+1].zero  <= sq_item_reg[j].zero;
            sq_item_reg[j+1].sumsq <= {sq_item_reg[j].sumsq[61:0], 2'b00};
        end
    end

    // Dividend is mag * 2^30 plus half the root, for rounding to nearest.
    always_ff @(posedge clk)
    begin
        logic [61:0] num;
        for (int c = 0; c < 4; c++)
        begin
            num = {1'b0, sq_item_reg[SQ_STEPS].mag[c], 30'd0}
                + {31'd0, sq_root_reg[SQ_STEPS][ROOT_W-1:1]};
            dv_rem_reg[0][c] <= {2'b00, num[61:31]};
            dv_low_reg[0][c] <= num[30:0];
            dv_quo_reg[0][c] <= '0;
        end
        dv_div_reg[0]  <= sq_root_reg[SQ_STEPS];
        dv_neg_reg[0]  <= sq_item_reg[SQ_STEPS].neg;
        dv_zero_reg[0] <= sq_item_reg[SQ_STEPS].zero;
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            logic [32:0] rs;
            logic        ge;
            for (int c = 0; c < 4; c++)
            begin
                rs = {dv_rem_reg[j][c][31:0], dv_low_reg[j][c][30]};
                ge = rs >= {1'b0, dv_div_reg[j]};
                dv_rem_reg[j+1][c] <= ge ? rs - {1'b0, dv_div_reg[j]} : rs;
                dv_low_reg[j+1][c] <= {dv_low_reg[j][c][29:0], 1'b0};
                dv_quo_reg[j+1][c] <= {dv_quo_reg[j][c][29:0], ge};
            end
            dv_div_reg[j+1]  <= dv_div_reg[j];
            dv_neg_reg[j+1]  <= dv_neg_reg[j];
            dv_zero_reg[j+1] <= dv_zero_reg[j];
        end
    end

    assign out_valid = dv_vld_reg[DIV_STEPS];
    assign quo       = dv_quo_reg[DIV_STEPS];
    assign neg       = dv_neg_reg[DIV_STEPS];
    assign zero      = dv_zero_reg[DIV_STEPS];

endmodule

// File: design/quaternion_multiply_normalize_unit.sv
// Top level of the quaternion multiply and normalize unit.
// Depends on qmn_pkg, qmn_front, qmn_queue and qmn_back.
//
// Usage: a word (func and the two Q1.30 quaternions a and b) is taken at a
// rising edge where start is high and busy is low. Each word gives exactly
// one result word, shown on r_x, r_y, r_z, r_w and zero_norm for a single
// cycle while done is high. The receiver cannot hold results back.
//
// Throughput is one word per cycle. A word passes ten front stages
// (products, sums, shift search, squares), one through the queue, 33
// square root stages (an input register, then one root bit per stage),
// 32 divider stages (the dividend register, then one quotient bit per
// stage) and the output register.
//
// The back part never stalls and reads the queue whenever it holds a word,
// so the queue never fills and busy stays low in normal use. Reset clears
// every valid bit, the queue pointers and count; nothing else is cleared, and no
// result is shown until a word has gone through the whole pipeline.
module quaternion_multiply_normalize_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] b_w,
    output logic               done,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic [30:0]        r_w,
    output logic               zero_norm
);
    import qmn_pkg::*;

    logic              fr_valid, q_not_empty, q_full, bk_valid, bk_zero;
    norm_item_t        fr_item, q_item;
    logic [3:0][30:0]  bk_quo;
    logic [2:0]        bk_neg;
    logic              done_reg;
    logic [31:0]       rx_reg, ry_reg, rz_reg;
    logic [30:0]       rw_reg;
    logic              zero_reg;
    logic [2:0][31:0]  vec_next;

    // The front part takes a word on every accepted start.
    qmn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .func      (func),
        .a         ({a_w, a_z, a_y, a_x}),
        .b         ({b_w, b_z, b_y, b_x}),
        .out_valid (fr_valid),
        .out_item  (fr_item)
    );

    qmn_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_valid),
        .din       (fr_item),
        .pop       (q_not_empty),
        .dout      (q_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    qmn_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_not_empty),
        .in_item   (q_item),
        .out_valid (bk_valid),
        .quo       (bk_quo),
        .neg       (bk_neg),
        .zero      (bk_zero)
    );

    assign busy = q_full;

    // Apply the signs to the vector part; a zero magnitude gives all zeros.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            vec_next[c] = bk_neg[c] ? -{1'b0, bk_quo[c]} : {1'b0, bk_quo[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= bk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= bk_zero;
        rx_reg   <= bk_zero ? '0 : vec_next[0];
        ry_reg   <= bk_zero ? '0 : vec_next[1];
        rz_reg   <= bk_zero ? '0 : vec_next[2];
        rw_reg   <= bk_zero ? '0 : bk_quo[3];
    end

    assign done      = done_reg;
    assign r_x       = rx_reg;
    assign r_y       = ry_reg;
    assign r_z       = rz_reg;
    assign r_w       = rw_reg;
    assign zero_norm = zero_reg;

`ifndef NO_ASSERTIONS
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_norm) |-> (r_x == 0 && r_y == 0 && r_z == 0 && r_w == 0))
        else $error("zero magnitude result not cleared");
    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !zero_norm) |-> (r_w <= 31'h4000_0000))
        else $error("scalar part above one");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quaternion multiply and normalize unit.
// Depends on qmn_pkg and the quaternion_multiply_normalize_unit design files.
module tb_top;

    import qmn_pkg::*;

    // One input word as handed to the unit.
    typedef struct {
        logic [1:0]         fn;
        logic signed [31:0] ax, ay, az, aw;
        logic signed [31:0] bx, by, bz, bw;
    } quat_pair_t;

    // One result word as the unit should show it.
    typedef struct {
        logic signed [31:0] x, y, z;
        logic [30:0]        w;
        logic               zn;
    } unit_quat_t;

    localparam int LATENCY = 77;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         func;
    logic signed [31:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
    logic               done;
    logic signed [31:0] r_x, r_y, r_z;
    logic [30:0]        r_w;
    logic               zero_norm;

    quat_pair_t pending_pairs[$];
    unit_quat_t expected_quats[$];
    int         fail_count = 0;
    bit         stim_done = 0;
    bit         drain_req = 0;

    quaternion_multiply_normalize_unit uut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .done(done), .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
        .zero_norm(zero_norm)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Product of two Q1.30 values, quartered with truncation towards zero.
    function automatic longint quarter_product(longint p, longint q);
        longint full;
        full = p * q;
        return full / 4;
    endfunction

    // Bitwise integer square root of a 64-bit value, rounded down.
    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= root + bitv)
            begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Works out the sign-normalised unit quaternion for one input word.
    function automatic unit_quat_t normalised_product(quat_pair_t p);
        unit_quat_t      res;
        longint          a[4], b[4], q[4];
        longint unsigned mag[4], m, s, root, r[4];
        bit              neg[4];
        a[0] = p.ax; a[1] = p.ay; a[2] = p.az; a[3] = p.aw;
        b[0] = p.bx; b[1] = p.by; b[2] = p.bz; b[3] = p.bw;
        if (p.fn == FUNC_CONJA_B || p.fn == FUNC_CONJA)
            for (int i = 0; i < 3; i++) a[i] = -a[i];
        if (p.fn == FUNC_A_CONJB)
            for (int i = 0; i < 3; i++) b[i] = -b[i];
        if (p.fn == FUNC_CONJA)
            q = a;
        else
        begin
            q[0] = quarter_product(b[3], a[0]) + quarter_product(b[2], a[1])
                 - quarter_product(b[1], a[2]) + quarter_product(b[0], a[3]);
            q[1] = -quarter_product(b[2], a[0]) + quarter_product(b[3], a[1])
                 + quarter_product(b[0], a[2]) + quarter_product(b[1], a[3]);
            q[2] = quarter_product(b[1], a[0]) - quarter_product(b[0], a[1])
                 + quarter_product(b[3], a[2]) + quarter_product(b[2], a[3]);
            q[3] = -quarter_product(b[0], a[0]) - quarter_product(b[1], a[1])
                 - quarter_product(b[2], a[2]) + quarter_product(b[3], a[3]);
        end
        m = 0;
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = q[i] < 0;
            mag[i] = neg[i] ? -q[i] : q[i];
            if (mag[i] > m) m = mag[i];
        end
        res = '{x: 0, y: 0, z: 0, w: 0, zn: 1'b1};
        if (m == 0)
            return res;
        // A negative scalar flips every sign so that the scalar ends up positive.
        if (q[3] < 0)
            for (int i = 0; i < 4; i++) neg[i] = !neg[i];
        while (m >= (64'd1 << 31))
        begin
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 30))
        begin
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
            m <<= 1;
        end
        s = 0;
        for (int i = 0; i < 4; i++) s += mag[i] * mag[i];
        root = floor_sqrt(s);
        for (int i = 0; i < 4; i++)
            r[i] = ((mag[i] << 30) + (root >> 1)) / root;
        res.x  = neg[0] ? -r[0][31:0] : r[0][31:0];
        res.y  = neg[1] ? -r[1][31:0] : r[1][31:0];
        res.z  = neg[2] ? -r[2][31:0] : r[2][31:0];
        res.w  = r[3][30:0];
        res.zn = 1'b0;
        return res;
    endfunction

    // Component values biased towards the extremes and small magnitudes.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 15) - 8;
            4: return 32'h4000_0000;
            5: return 32'hc000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic quat_pair_t make_pair(logic [1:0] fn, logic [31:0] ax, logic [31:0] ay,
                                             logic [31:0] az, logic [31:0] aw, logic [31:0] bx,
                                             logic [31:0] by, logic [31:0] bz, logic [31:0] bw);
        quat_pair_t p;
        p = '{fn, ax, ay, az, aw, bx, by, bz, bw};
        return p;
    endfunction

    // Stimulus: directed words first, then random words with random content.
    initial
    begin
        logic [31:0] one;
        one = 32'h4000_0000;
        // Identity products under every operation.
        for (int f = 0; f < 4; f++)
            pending_pairs.push_back(make_pair(2'(f), 0, 0, 0, one, 0, 0, 0, one));
        // Zero magnitude, for a product and for a lone conjugate.
        pending_pairs.push_back(make_pair(FUNC_AB, 0, 0, 0, 0, 1, 2, 3, 4));
        pending_pairs.push_back(make_pair(FUNC_CONJA, 0, 0, 0, 0, '1, '1, '1, '1));
        // Negative scalar, zero scalar and a tiny scalar that the shift drops.
        pending_pairs.push_back(make_pair(FUNC_CONJA, 5, 6, 7, -9, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(FUNC_CONJA, 32'h7fff_ffff, 3, -3, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(FUNC_CONJA, 32'h8000_0000, 0, 0, -1, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(FUNC_CONJA, 32'h7fff_ffff, 0, 0, 1, 0, 0, 0, 0));
        // Most negative and most positive values everywhere.
        for (int f = 0; f < 4; f++)
        begin
            pending_pairs.push_back(make_pair(2'(f), '1 << 31, '1 << 31, '1 << 31, '1 << 31,
                                              '1 << 31, '1 << 31, '1 << 31, '1 << 31));
            pending_pairs.push_back(make_pair(2'(f), 32'h7fff_ffff, 32'h8000_0000,
                                              32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        end
        // Products that quarter to zero, and the smallest value times zero.
        pending_pairs.push_back(make_pair(FUNC_AB, 1, 0, 0, 1, 0, 0, 0, 1));
        pending_pairs.push_back(make_pair(FUNC_A_CONJB, 0, 0, 0, 1, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(FUNC_CONJA_B, 0, 1, 0, 0, 0, 0, 0, 0));
        for (int n = 0; n < 2000; n++)
            pending_pairs.push_back(make_pair(2'($urandom_range(0, 3)), rand_comp(),
                                              rand_comp(), rand_comp(), rand_comp(),
                                              rand_comp(), rand_comp(), rand_comp(),
                                              rand_comp()));
        stim_done = 1;
    end

    // Driver: one word per handshake, with a random gap drawn before each word.
    // Once, midway, it holds off until every expected word has come back.
    always @(posedge clk or negedge rst_n)
    begin
        static int gap = 0;
        static int sent = 0;
        quat_pair_t p;
        if (!rst_n)
        begin
            start <= 1'b0;
            func  <= '0;
            a_x <= '0; a_y <= '0; a_z <= '0; a_w <= '0;
            b_x <= '0; b_y <= '0; b_z <= '0; b_w <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                sent++;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (sent == 800) drain_req = 1;
            end
            if (start && busy)
                ; // hold the word until it is taken
            else if (drain_req && expected_quats.size() != 0)
                start <= 1'b0;
            else if (gap > 0)
            begin
                drain_req = 0;
                gap--;
                start <= 1'b0;
            end
            else if (pending_pairs.size() != 0)
            begin
                drain_req = 0;
                p = pending_pairs.pop_front();
                expected_quats.push_back(normalised_product(p));
                start <= 1'b1;
                func  <= p.fn;
                a_x <= p.ax; a_y <= p.ay; a_z <= p.az; a_w <= p.aw;
                b_x <= p.bx; b_y <= p.by; b_z <= p.bz; b_w <= p.bw;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every done cycle carries one result word to compare in order.
    always @(posedge clk)
    begin
        unit_quat_t e;
        if (rst_n && done)
        begin
            if (expected_quats.size() == 0)
            begin
                $error("result word with none expected");
                fail_count++;
            end
            else
            begin
                e = expected_quats.pop_front();
                if (r_x !== e.x)
                begin
                    $error("r_x expected %0d actual %0d", e.x, r_x);
                    fail_count++;
                end
                if (r_y !== e.y)
                begin
                    $error("r_y expected %0d actual %0d", e.y, r_y);
                    fail_count++;
                end
                if (r_z !== e.z)
                begin
                    $error("r_z expected %0d actual %0d", e.z, r_z);
                    fail_count++;
                end
                if (r_w !== e.w)
                begin
                    $error("r_w expected %0d actual %0d", e.w, r_w);
                    fail_count++;
                end
                if (zero_norm !== e.zn)
                begin
                    $error("zero_norm expected %0d actual %0d", e.zn, zero_norm);
                    fail_count++;
                end
            end
        end
    end

    // Reset, then wait for all words to be taken and every result to return.
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        @(posedge clk);
        while (pending_pairs.size() != 0 || start || expected_quats.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && expected_quats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
